@@ design/hfir_pkg.sv @@
// shared widths, beat type and register indexes for the horizontal fir filter
// no dependencies; imported by every module of the block
package hfir_pkg;

   localparam int PIX_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int COEF_W     = 12;
   localparam int COEF_SLOTS = 9;
   localparam int COEF_ALL_W = COEF_W * COEF_SLOTS;
   localparam int COEF_LO_W  = 60;
   localparam int COEF_HI_W  = 48;
   localparam int HW_W       = 3;
   localparam int HALF_LIMIT = 4;
   localparam int SCALE_W    = 18;
   localparam int BIAS_W     = 25;
   localparam int FRAC_W     = 16;
   localparam int BIAS_SHIFT = 8;
   localparam int ROUND_HALF = 32768;
   localparam int PROD_W     = PIX_W + 1 + COEF_W;
   localparam int SUM_W      = 32;
   localparam int MUL_W      = SUM_W + SCALE_W + 1;
   localparam int T_W        = MUL_W + 1;
   localparam int Q_W        = T_W - FRAC_W;
   localparam int MAX_NARROW = 255;
   localparam int MAX_DEEP   = 65535;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEEP      = 3'd6;

   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic signed [SUM_W-1:0] sum;
   } hfir_beat_type;

endpackage

@@ design/hfir_tap_cell.sv @@
// one multiply-accumulate cell of the tap chain
// depends on hfir_pkg for the beat type and widths
module hfir_tap_cell #(
   parameter int TAPS  = 9,
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic signed [hfir_pkg::COEF_W-1:0]  coef,
   input  hfir_pkg::hfir_beat_type             beat_in,
   input  logic [hfir_pkg::PIX_W-1:0]          pix_in [TAPS],
   output hfir_pkg::hfir_beat_type             beat_out,
   output logic [hfir_pkg::PIX_W-1:0]          pix_out [TAPS]
);
   import hfir_pkg::*;

   hfir_beat_type           beat_ff, beat_in_nx;
   logic [PIX_W-1:0]        pix_ff [TAPS];
   logic signed [PROD_W-1:0] prod;

   assign prod = $signed({1'b0, pix_in[INDEX]}) * coef;

   always_comb begin
      beat_in_nx = beat_in;
      beat_in_nx.sum = $signed(beat_in.sum) + SUM_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff.valid <= beat_in_nx.valid;
      end
      if (advance) begin
         beat_ff.last <= beat_in_nx.last;
         beat_ff.sum  <= beat_in_nx.sum;
         pix_ff       <= pix_in;
      end
   end

   assign beat_out = beat_ff;
   assign pix_out  = pix_ff;

endmodule

@@ design/hfir_scaler.sv @@
// scale, bias, rounding and clamp stages ending in the result register
// depends on hfir_pkg for the beat type and widths
module hfir_scaler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  hfir_pkg::hfir_beat_type             beat_in,
   input  logic [hfir_pkg::SCALE_W-1:0]        scale,
   input  logic signed [hfir_pkg::BIAS_W-1:0]  bias,
   input  logic                                fold,
   input  logic                                deep,
   output logic                                out_valid,
   output logic [hfir_pkg::PIX_W-1:0]          out_pixel,
   output logic                                out_last
);
   import hfir_pkg::*;

   logic                    m_valid_ff, m_last_ff;
   logic signed [MUL_W-1:0] m_prod_ff, m_prod_in;
   logic                    a_valid_ff, a_last_ff;
   logic signed [T_W-1:0]   a_t_ff, a_t_in, offset;
   logic                    o_valid_ff, o_last_ff;
   logic [PIX_W-1:0]        o_pixel_ff, o_pixel_in;
   logic                    neg;
   logic [T_W-1:0]          mag;
   logic [Q_W-1:0]          quot, limit;

   assign m_prod_in = $signed(beat_in.sum) * $signed({1'b0, scale});
   assign offset    = ($signed(T_W'(bias)) <<< BIAS_SHIFT) + T_W'(ROUND_HALF);
   assign a_t_in    = T_W'(m_prod_ff) + offset;

   assign neg   = a_t_ff[T_W-1];
   assign mag   = neg ? (~a_t_ff + 1'b1) : a_t_ff;
   assign quot  = mag[T_W-1:FRAC_W];
   assign limit = deep ? Q_W'(MAX_DEEP) : Q_W'(MAX_NARROW);

   always_comb begin
      if (neg && !fold) begin
         o_pixel_in = '0;
      end else if (quot > limit) begin
         o_pixel_in = limit[PIX_W-1:0];
      end else begin
         o_pixel_in = quot[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= beat_in.valid;
         a_valid_ff <= m_valid_ff;
         o_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         m_last_ff  <= beat_in.last;
         m_prod_ff  <= m_prod_in;
         a_last_ff  <= m_last_ff;
         a_t_ff     <= a_t_in;
         o_last_ff  <= a_last_ff;
         o_pixel_ff <= o_pixel_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_pixel = o_pixel_ff;
   assign out_last  = o_last_ff;

endmodule

@@ design/horizontal_fir_pixel_filter.sv @@
// top level of the horizontal fir pixel filter: registers, pixel window, sequencer
// depends on hfir_pkg, hfir_tap_cell and hfir_scaler
//
// req channel: one pixel beat with a line end flag, valid/ready.
// rsp channel: one filtered pixel beat with a line end flag, valid/ready.
// csr port: csr_write with csr_index and csr_data, taken at once; user must write only while idle (unchecked).
// each pixel beat of a line yields one result once half_width + 1 pixels have
// arrived; the line end beat yields every result still owed, up to half_width + 1,
// the last one flagged, and returns the line position to zero.
// throughput: one pixel per cycle inside a line while rsp_ready does not hold the
// chain, set by the sequencer issuing one output position per cycle into the tap
// chain; after a line end beat the next pixel is taken once its last result issues.
// from pixel beat to result the path runs through the sequencer job registers, the
// window gather register, the tap cell registers and the scaler's multiply, offset and clamp registers.
// reset clears the line position, the pipeline valids and the registers to
// their defaults. when rsp_ready is low with a result held, the whole chain
// freezes and req_ready drops.
module horizontal_fir_pixel_filter #(
   parameter int MAX_TAPS = 9,
   parameter int MAX_LINE = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [hfir_pkg::PIX_W-1:0]           req_pixel_in,
   input  logic                                 req_line_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hfir_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic                                 rsp_line_end_out,
   input  logic                                 csr_write,
   input  logic [hfir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hfir_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hfir_pkg::*;

   localparam int HMAX      = ((MAX_TAPS - 1) / 2 < HALF_LIMIT) ? (MAX_TAPS - 1) / 2
                                                                : HALF_LIMIT;
   localparam int TAPS      = 2 * HMAX + 1;
   localparam int WIN_IW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int POS_W     = $clog2(MAX_LINE);
   localparam int SW        = POS_W + 2;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

   // configuration registers
   logic [COEF_LO_W-1:0]     coef_low_ff;
   logic [COEF_HI_W-1:0]     coef_high_ff;
   logic [HW_W-1:0]          half_ff;
   logic [SCALE_W-1:0]       scale_ff;
   logic signed [BIAS_W-1:0] bias_ff;
   logic                     fold_ff, deep_ff;
   logic [COEF_ALL_W-1:0]    coef_all;
   logic [HW_W-1:0]          b_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_low_ff  <= '0;
         coef_high_ff <= '0;
         half_ff      <= 3'd1;
         scale_ff     <= 18'd65536;
         bias_ff      <= '0;
         fold_ff      <= 1'b0;
         deep_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COEF_LOW:  coef_low_ff  <= csr_data;
            CSR_COEF_HIGH: coef_high_ff <= csr_data[COEF_HI_W-1:0];
            CSR_HALF:      half_ff      <= csr_data[HW_W-1:0];
            CSR_SCALE:     scale_ff     <= csr_data[SCALE_W-1:0];
            CSR_BIAS:      bias_ff      <= $signed(csr_data[BIAS_W-1:0]);
            CSR_FOLD:      fold_ff      <= csr_data[0];
            CSR_DEEP:      deep_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign coef_all = {coef_high_ff, coef_low_ff};
   assign b_eff    = (half_ff > HW_W'(HMAX)) ? HW_W'(HMAX) : half_ff;

   // handshake and sequencer
   logic             adv, accept, issue, job_done, reach;
   logic [POS_W-1:0] line_pos_ff, line_pos_in;
   logic             job_active_ff, job_active_in;
   logic [POS_W-1:0] job_x_ff, job_x_in, job_hi_ff, job_hi_in, job_n_ff, job_n_in;
   logic             job_last_ff, job_last_in;
   logic [POS_W-1:0] b_ext;

   assign adv       = !rsp_valid || rsp_ready;
   assign job_done  = job_x_ff == job_hi_ff;
   assign issue     = adv && job_active_ff;
   assign req_ready = adv && (!job_active_ff || job_done);
   assign accept    = req_valid && req_ready;
   assign b_ext     = POS_W'(b_eff);
   assign reach     = line_pos_ff >= b_ext;

   always_comb begin
      line_pos_in   = line_pos_ff;
      job_active_in = job_active_ff;
      job_x_in      = job_x_ff;
      job_hi_in     = job_hi_ff;
      job_n_in      = job_n_ff;
      job_last_in   = job_last_ff;
      if (issue) begin
         if (job_done) begin
            job_active_in = 1'b0;
         end else begin
            job_x_in = job_x_ff + 1'b1;
         end
      end
      if (accept) begin
         job_n_in = line_pos_ff;
         if (req_line_end) begin
            line_pos_in   = '0;
            job_active_in = 1'b1;
            job_x_in      = reach ? line_pos_ff - b_ext : '0;
            job_hi_in     = line_pos_ff;
            job_last_in   = 1'b1;
         end else begin
            if (line_pos_ff < POS_MAX) begin
               line_pos_in = line_pos_ff + 1'b1;
            end
            job_active_in = reach;
            job_x_in      = line_pos_ff - b_ext;
            job_hi_in     = line_pos_ff - b_ext;
            job_last_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff   <= '0;
         job_active_ff <= 1'b0;
      end else begin
         line_pos_ff   <= line_pos_in;
         job_active_ff <= job_active_in;
      end
      job_x_ff    <= job_x_in;
      job_hi_ff   <= job_hi_in;
      job_n_ff    <= job_n_in;
      job_last_ff <= job_last_in;
   end

   // pixel window, newest first
   logic [PIX_W-1:0] win_ff [TAPS];
   logic [PIX_W-1:0] pix_masked;

   assign pix_masked = deep_ff ? req_pixel_in : {{(PIX_W-BYTE_W){1'b0}}, req_pixel_in[BYTE_W-1:0]};

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= pix_masked;
         for (int i = 1; i < TAPS; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   // gather tap pixels with mirrored edges
   logic signed [SW-1:0] x_s, n_s, b_s;
   logic [PIX_W-1:0]     gather_pix [TAPS];

   assign x_s = $signed({2'b00, job_x_ff});
   assign n_s = $signed({2'b00, job_n_ff});
   assign b_s = $signed(SW'(b_eff));

   always_comb begin
      logic signed [SW-1:0] pos_j;
      logic signed [SW-1:0] lag;
      for (int k = 0; k < TAPS; k++) begin
         pos_j = x_s - b_s + SW'(k);
         if (pos_j < 0) begin
            pos_j = -pos_j;
         end
         if (pos_j > n_s) begin
            pos_j = (n_s <<< 1) - pos_j;
         end
         if (pos_j < 0) begin
            pos_j = '0;
         end
         if (pos_j > n_s) begin
            pos_j = n_s;
         end
         lag = n_s - pos_j;
         gather_pix[k] = '0;
         if (lag < SW'(TAPS) && 4'(k) <= {b_eff, 1'b0}) begin
            gather_pix[k] = win_ff[lag[WIN_IW-1:0]];
         end
      end
   end

   hfir_beat_type    s0_ff;
   logic [PIX_W-1:0] s0_pix_ff [TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff.valid <= job_active_ff;
      end
      if (adv) begin
         s0_ff.last <= job_last_ff && job_done;
         s0_ff.sum  <= '0;
         s0_pix_ff  <= gather_pix;
      end
   end

   // tap chain
   hfir_beat_type    chain_beat [TAPS+1];
   logic [PIX_W-1:0] chain_pix [TAPS][TAPS];

   assign chain_beat[0] = s0_ff;
   assign chain_pix[0]  = s0_pix_ff;

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      if (k < TAPS - 1) begin : g_mid
         hfir_tap_cell #(.TAPS(TAPS), .INDEX(k)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (adv),
            .coef     ($signed(coef_all[COEF_W*k +: COEF_W])),
            .beat_in  (chain_beat[k]),
            .pix_in   (chain_pix[k]),
            .beat_out (chain_beat[k+1]),
            .pix_out  (chain_pix[k+1])
         );
      end else begin : g_tail
         hfir_tap_cell #(.TAPS(TAPS), .INDEX(k)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (adv),
            .coef     ($signed(coef_all[COEF_W*k +: COEF_W])),
            .beat_in  (chain_beat[k]),
            .pix_in   (chain_pix[k]),
            .beat_out (chain_beat[k+1]),
            .pix_out  ()
         );
      end
   end

   hfir_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .beat_in   (chain_beat[TAPS]),
      .scale     (scale_ff),
      .bias      (bias_ff),
      .fold      (fold_ff),
      .deep      (deep_ff),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out),
      .out_last  (rsp_line_end_out)
   );

endmodule

@@ bench/tb_horizontal_fir_pixel_filter.sv @@
`timescale 1ns / 100ps
// testbench for horizontal_fir_pixel_filter: a directed table and random lines under three
// idle mixes with a long receiver hold-off, checked beat by beat
// depends on hfir_pkg and the filter rtl; stands alone otherwise
module tb_horizontal_fir_pixel_filter;
   import hfir_pkg::*;

   localparam int WIN_DEPTH    = 9;
   localparam int LINE_CAP     = 4096;
   localparam int FLUSH_CYCLES = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [PIX_W-1:0]       pixel;
      logic                   line_end;
      bit                     typed;
      logic [PIX_W-1:0]       typed_out;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  data;
   } stim_row_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             line_end;
   } out_beat_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel_in     = '0;
   logic                  req_line_end     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_line_end_out;
   logic                  csr_write        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_data         = '0;

   horizontal_fir_pixel_filter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_in     (req_pixel_in),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_line_end_out (rsp_line_end_out),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state and register copies, newest pixel at index 0
   logic [PIX_W-1:0]          window_q [WIN_DEPTH] = '{default: '0};
   int                        line_pos  = 0;
   logic [COEF_LO_W-1:0]      coef_lo   = '0;
   logic [COEF_HI_W-1:0]      coef_hi   = '0;
   logic [HW_W-1:0]           half_reg  = 3'd1;
   logic [SCALE_W-1:0]        scale_reg = 18'd65536;
   logic signed [BIAS_W-1:0]  bias_reg  = '0;
   logic                      fold_reg  = 1'b0;
   logic                      deep_reg  = 1'b0;

   out_beat_type pending_pixels[$];
   int        mismatch_count = 0;
   int        req_idle_pct   = 0;
   int        rsp_idle_pct   = 0;
   int        hold_left      = 0;

   function automatic logic signed [COEF_W-1:0] coef_at(int k);
      if (k < 5)
         return coef_lo[COEF_W*k +: COEF_W];
      return coef_hi[COEF_W*(k-5) +: COEF_W];
   endfunction

   function automatic logic [PIX_W-1:0] filtered_at(int x, int n, int b);
      longint           acc;
      longint           t;
      longint           mag;
      longint           q;
      int               j;
      int               d;
      int               k;
      logic [PIX_W-1:0] p;
      acc = 0;
      for (k = 0; k <= 2*b; k++) begin
         j = x - b + k;
         // mirror without repeating the edge pixel, then clamp for short lines
         if (j < 0) j = -j;
         if (j > n) j = 2*n - j;
         if (j < 0) j = 0;
         if (j > n) j = n;
         d = n - j;
         p = (d >= 0 && d < WIN_DEPTH) ? window_q[d] : '0;
         acc += longint'(p) * longint'(coef_at(k));
      end
      t = acc * longint'(scale_reg) + longint'(bias_reg) * (1 << BIAS_SHIFT) + ROUND_HALF;
      mag = (t < 0) ? -t : t;
      q = mag >> FRAC_W;
      if (t < 0 && !fold_reg) q = 0;
      if (deep_reg) begin
         if (q > MAX_DEEP) q = MAX_DEEP;
      end else if (q > MAX_NARROW) begin
         q = MAX_NARROW;
      end
      return PIX_W'(q);
   endfunction

   function automatic void advance_window(logic [PIX_W-1:0] pix, logic le);
      int b;
      int n;
      int start;
      int i;
      int x;
      b = (half_reg > HALF_LIMIT) ? HALF_LIMIT : int'(half_reg);
      for (i = WIN_DEPTH-1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = deep_reg ? pix : {{(PIX_W-BYTE_W){1'b0}}, pix[BYTE_W-1:0]};
      n = line_pos;
      if (line_pos < LINE_CAP-1) line_pos++;
      if (le) begin
         start = (n - b < 0) ? 0 : n - b;
         for (x = start; x <= n; x++)
            pending_pixels.push_back('{pixel: filtered_at(x, n, b), line_end: (x == n)});
         line_pos = 0;
      end else if (n >= b) begin
         pending_pixels.push_back('{pixel: filtered_at(n - b, n, b), line_end: 1'b0});
      end
   endfunction

   function automatic void load_register(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_COEF_LOW:  coef_lo   = data[COEF_LO_W-1:0];
         CSR_COEF_HIGH: coef_hi   = data[COEF_HI_W-1:0];
         CSR_HALF:      half_reg  = data[HW_W-1:0];
         CSR_SCALE:     scale_reg = data[SCALE_W-1:0];
         CSR_BIAS:      bias_reg  = signed'(data[BIAS_W-1:0]);
         CSR_FOLD:      fold_reg  = data[0];
         CSR_DEEP:      deep_reg  = data[0];
         default: ;
      endcase
   endfunction

   function automatic stim_row_type pixel_row(logic [PIX_W-1:0] pix, logic le);
      return '{ROW_PIXEL, pix, le, 1'b0, '0, '0, '0};
   endfunction

   function automatic stim_row_type typed_row(logic [PIX_W-1:0] pix, logic le,
                                              logic [PIX_W-1:0] out_val);
      return '{ROW_PIXEL, pix, le, 1'b1, out_val, '0, '0};
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      return '{ROW_CSR, '0, 1'b0, 1'b0, '0, idx, data};
   endfunction

   // all tasks start and return at a falling edge
   task automatic send_pixel(logic [PIX_W-1:0] pix, logic le, bit typed,
                             logic [PIX_W-1:0] typed_val);
      int first;
      int i;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_pixel_in = pix;
      req_line_end = le;
      do @(posedge clock); while (!req_ready);
      first = pending_pixels.size();
      advance_window(pix, le);
      if (typed)
         for (i = first; i < pending_pixels.size(); i++) pending_pixels[i].pixel = typed_val;
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      load_register(idx, data);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_config();
      logic [63:0]          raw;
      logic [COEF_LO_W-1:0] lo;
      logic [COEF_HI_W-1:0] hi;
      logic [SCALE_W-1:0]   sc;
      logic [BIAS_W-1:0]    bs;
      int                   pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 3);
      lo   = (pick == 0) ? {5{12'h800}} : (pick == 1) ? {5{12'h7FF}} : raw[COEF_LO_W-1:0];
      write_register(CSR_COEF_LOW, lo);
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 3);
      hi   = (pick == 0) ? {4{12'h800}} : (pick == 1) ? {4{12'h7FF}} : raw[COEF_HI_W-1:0];
      write_register(CSR_COEF_HIGH, {raw[59:48], hi});
      raw  = {$urandom, $urandom};
      write_register(CSR_HALF, {raw[59:3], 3'($urandom_range(0, 7))});
      raw  = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0:       sc = '0;
         1:       sc = '1;
         2:       sc = 18'($urandom_range(0, 2048));
         default: sc = 18'($urandom_range(0, 262143));
      endcase
      write_register(CSR_SCALE, {raw[59:18], sc});
      raw  = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0:       bs = 25'h0FF_FFFF;
         1:       bs = 25'h100_0000;
         default: bs = 25'(int'($urandom_range(0, 131072)) - 65536);
      endcase
      write_register(CSR_BIAS, {raw[59:25], bs});
      raw  = {$urandom, $urandom};
      write_register(CSR_FOLD, {raw[59:1], 1'($urandom_range(0, 1))});
      raw  = {$urandom, $urandom};
      write_register(CSR_DEEP, {raw[59:1], 1'($urandom_range(0, 1))});
   endtask

   task automatic send_line(int len);
      logic [PIX_W-1:0] pix;
      int               i;
      for (i = 0; i < len; i++) begin
         pix = PIX_W'($urandom_range(0, 65535));
         if ($urandom_range(0, 7) == 0) pix = $urandom_range(0, 1) ? '1 : '0;
         send_pixel(pix, i == len - 1, 1'b0, '0);
      end
   endtask

   // receiver side: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected rsp beat: pixel_out %0d line_end_out %0d",
                   rsp_pixel_out, rsp_line_end_out);
            mismatch_count++;
         end else begin
            if (rsp_pixel_out !== pending_pixels[0].pixel) begin
               $error("pixel_out: expected %0d, got %0d",
                      pending_pixels[0].pixel, rsp_pixel_out);
               mismatch_count++;
            end
            if (rsp_line_end_out !== pending_pixels[0].line_end) begin
               $error("line_end_out: expected %0d, got %0d",
                      pending_pixels[0].line_end, rsp_line_end_out);
               mismatch_count++;
            end
            void'(pending_pixels.pop_front());
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** horizontal_fir_pixel_filter: FAILED **");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      int        sent;
      int        len;
      int        mode;
      int        set_no;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers at reset give all-zero taps, so every beat comes out zero
      rows = '{
         typed_row(16'hFFFF, 1'b0, 16'd0),
         typed_row(16'h0000, 1'b0, 16'd0),
         typed_row(16'h00FF, 1'b1, 16'd0),
         typed_row(16'hAAAA, 1'b1, 16'd0),
         csr_row(CSR_BIAS, 60'h0FF_FFFF),
         csr_row(CSR_DEEP, 60'h1),
         typed_row(16'h5555, 1'b1, 16'(MAX_DEEP)),
         csr_row(CSR_DEEP, 60'h0),
         typed_row(16'h1234, 1'b0, 16'(MAX_NARROW)),
         typed_row(16'h8001, 1'b1, 16'(MAX_NARROW)),
         csr_row(CSR_BIAS, 60'h100_0000),
         typed_row(16'h7777, 1'b1, 16'd0),
         csr_row(CSR_FOLD, 60'h1),
         typed_row(16'h0F0F, 1'b1, 16'(MAX_NARROW)),
         csr_row(CSR_DEEP, 60'h1),
         typed_row(16'hF0F0, 1'b1, 16'(MAX_DEEP)),
         csr_row(CSR_BIAS, 60'h0),
         csr_row(CSR_FOLD, 60'h0),
         csr_row(CSR_COEF_LOW, 60'h7FF_800_123_FFF_001),
         csr_row(CSR_COEF_HIGH, 60'h800_7FF_456_ABC),
         csr_row(CSR_HALF, 60'h4),
         csr_row(CSR_SCALE, 60'h400),
         // lines shorter than the mirror reach
         pixel_row(16'hFFFF, 1'b1),
         pixel_row(16'h0001, 1'b0),
         pixel_row(16'hFFFF, 1'b1),
         pixel_row(16'h8000, 1'b0),
         pixel_row(16'h7FFF, 1'b0),
         pixel_row(16'hC3C3, 1'b1),
         // half width of seven saturates, eight-bit pixels drop the upper byte
         csr_row(CSR_HALF, 60'hFFF_FFFF_FFFF_FFFF),
         csr_row(CSR_DEEP, 60'h0),
         csr_row(CSR_SCALE, 60'h3FFFF),
         pixel_row(16'hFF00, 1'b0),
         pixel_row(16'h00FF, 1'b0),
         pixel_row(16'h8080, 1'b0),
         pixel_row(16'h7F7F, 1'b0),
         pixel_row(16'hFFFF, 1'b0),
         pixel_row(16'h0000, 1'b1),
         csr_row(CSR_HALF, 60'h0),
         csr_row(CSR_SCALE, 60'h0),
         csr_row(CSR_SPARE, 60'hFFF_FFFF_FFFF_FFFF),
         pixel_row(16'h1234, 1'b0),
         pixel_row(16'h4321, 1'b1),
         csr_row(CSR_HALF, 60'hABC_DEF0_1234_567A),
         csr_row(CSR_SCALE, 60'h10000),
         pixel_row(16'hBEEF, 1'b0),
         pixel_row(16'hCAFE, 1'b1)
      };

      req_idle_pct = 15;
      rsp_idle_pct = 46;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            settle();
            write_register(rows[i].index, rows[i].data);
         end else begin
            send_pixel(rows[i].pixel, rows[i].line_end, rows[i].typed, rows[i].typed_out);
         end
      end

      for (mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 46 : 0;
         rsp_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 15 : 0;
         for (set_no = 0; set_no < 2; set_no++) begin
            settle();
            random_config();
            if (mode == 2 && set_no == 0) begin
               // receiver holds off while the sender keeps the input busy
               hold_left = 120;
               send_line(16);
            end
            sent = 0;
            while (sent < 8) begin
               len = $urandom_range(1, 12);
               send_line(len);
               sent += len;
            end
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("** horizontal_fir_pixel_filter: PASSED **");
      else
         $display("** horizontal_fir_pixel_filter: FAILED **");
      $finish;
   end

endmodule
